@@ src/string_to_int_custom_radix_macros.svh @@
// assertion macros shared by the string to integer parser
`ifndef STRING_TO_INT_CUSTOM_RADIX_MACROS_SVH
`define STRING_TO_INT_CUSTOM_RADIX_MACROS_SVH

// checked on every rising clock edge, ignored while reset is held
`define STOI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define STOI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/stoi_pkg.sv @@
// types, constants and codes of the string to integer parser
package stoi_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int ALPHA_SLOTS = 16;
    localparam int DIGIT_W     = 4;
    localparam int ACC_W       = 32;
    localparam int RADIX_W     = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_W       = 5;

    typedef logic [7:0] t_char;

    // character codes
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_BLANK_LO = 8'd9;
    localparam t_char CH_BLANK_HI = 8'd13;
    localparam t_char CH_MINUS = 8'h2d;
    localparam t_char CH_PLUS  = 8'h2b;

    // parse phase codes
    localparam logic [1:0] PH_BLANK = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 2'd3;

    localparam logic [RADIX_W-1:0] RADIX_INVALID = 6'h3f;

    typedef struct packed {
        logic [ALPHA_SLOTS-1:0][7:0] chars;
        logic [ALPHA_SLOTS-1:0]      pos_en;
        logic                        base_ok;
        logic [RADIX_W-1:0]          radix;
    } t_base;

endpackage

@@ src/stoi_in_if.sv @@
// character request channel
interface stoi_in_if import stoi_pkg::*; ();
    logic  valid;
    logic  ready;
    t_char char_code;
    logic  is_last;

    modport source (output valid, char_code, is_last, input ready);
    modport sink (input valid, char_code, is_last, output ready);
endinterface

@@ src/stoi_out_if.sv @@
// parsed value result channel
interface stoi_out_if import stoi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] value;
    logic                    base_ok;

    modport source (output valid, value, base_ok, input ready);
    modport sink (input valid, value, base_ok, output ready);
endinterface

@@ src/stoi_cfg.sv @@
// configuration registers and registered alphabet checks
module stoi_cfg import stoi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_base                 o_base
);

    localparam logic [LEN_W-1:0] MaxDigits = LEN_W'(MAX_DIGITS);

    logic [CFG_DATA_W-1:0]       r_alpha_lo;
    logic [CFG_DATA_W-1:0]       r_alpha_hi;
    logic [LEN_W-1:0]            r_alpha_len;
    logic [RADIX_W-1:0]          r_radix;
    logic [ALPHA_SLOTS-1:0]      r_pos_en;
    logic                        r_base_ok;

    logic [ALPHA_SLOTS-1:0][7:0] w_chars;
    logic [LEN_W-1:0]            w_len;
    logic [ALPHA_SLOTS-1:0]      n_pos_en;
    logic                        n_base_ok;
    logic                        w_bad_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_lo  <= '0;
            r_alpha_hi  <= '0;
            r_alpha_len <= '0;
            r_radix     <= '0;
            r_pos_en    <= '0;
            r_base_ok   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ALPHA_LO:  r_alpha_lo  <= i_cfg_data;
                    REG_ALPHA_HI:  r_alpha_hi  <= i_cfg_data;
                    REG_ALPHA_LEN: r_alpha_len <= i_cfg_data[LEN_W-1:0];
                    REG_RADIX:     r_radix     <= i_cfg_data[RADIX_W-1:0];
                    default: ;
                endcase
            end
            r_pos_en  <= n_pos_en;
            r_base_ok <= n_base_ok;
        end
    end

    assign w_chars = {r_alpha_hi, r_alpha_lo};
    assign w_len   = (r_alpha_len > MaxDigits) ? MaxDigits : r_alpha_len;

    // a slot is in use below the length and before the first zero byte
    always_comb begin
        logic run;
        run = 1'b1;
        for (int i = 0; i < ALPHA_SLOTS; i++) begin
            run         = run && (w_chars[i] != '0);
            n_pos_en[i] = run && (LEN_W'(i) < w_len);
        end
    end

    always_comb begin
        w_bad_char = 1'b0;
        for (int i = 0; i < ALPHA_SLOTS; i++) begin
            if (n_pos_en[i] && (w_chars[i] == CH_PLUS || w_chars[i] == CH_MINUS))
                w_bad_char = 1'b1;
            for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
                if (n_pos_en[j] && w_chars[j] == w_chars[i])
                    w_bad_char = 1'b1;
            end
        end
    end

    // at least two characters means slot 1 is in use
    assign n_base_ok = (r_radix != RADIX_INVALID) && n_pos_en[1] && !w_bad_char;

    assign o_base.chars   = w_chars;
    assign o_base.pos_en  = r_pos_en;
    assign o_base.base_ok = r_base_ok;
    assign o_base.radix   = r_radix;

endmodule

@@ src/string_to_int_custom_radix.sv @@
// a request is held in the input stage register, and a last character's result is then
// loaded into the output register; throughput: one character per cycle, set by the
// accumulator multiply-add loop, unless a last character waits on the output register
// reset clears the configuration registers to zero, the parse state to blank skipping
// with a zero accumulator and positive sign, and both channel stages to empty
module string_to_int_custom_radix import stoi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    stoi_in_if.sink               i_in,
    stoi_out_if.source            o_res
);

    `include "string_to_int_custom_radix_macros.svh"

    t_base                   w_base;

    logic                    r_in_valid;
    t_char                   r_char;
    logic                    r_last;

    logic [1:0]              r_phase;
    logic [ACC_W-1:0]        r_acc;
    logic                    r_neg;

    logic                    r_out_valid;
    logic [ACC_W-1:0]        r_out_value;
    logic                    r_out_ok;

    logic [1:0]              n_phase;
    logic [ACC_W-1:0]        n_acc;
    logic                    n_neg;
    logic [ACC_W-1:0]        n_value;

    logic                    w_adv;
    logic                    w_blank;
    logic                    w_hit;
    logic [DIGIT_W-1:0]      w_digit;
    logic [ACC_W-1:0]        w_radix;
    logic [ACC_W-1:0]        w_mac;

    stoi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_base      (w_base)
    );

    // a last character may only move on if the output register frees up
    assign w_adv      = r_in_valid && (!r_last || !r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.char_code;
            r_last <= i_in.is_last;
        end
    end

    assign w_blank = (r_char == CH_SPACE) || (r_char >= CH_BLANK_LO && r_char <= CH_BLANK_HI);

    // lowest matching slot wins
    always_comb begin
        w_hit   = 1'b0;
        w_digit = '0;
        for (int i = ALPHA_SLOTS - 1; i >= 0; i--) begin
            if (w_base.pos_en[i] && w_base.chars[i] == r_char) begin
                w_hit   = 1'b1;
                w_digit = DIGIT_W'(i);
            end
        end
    end

    assign w_radix = {{(ACC_W-RADIX_W){w_base.radix[RADIX_W-1]}}, w_base.radix};
    assign w_mac   = r_acc * w_radix + {{(ACC_W-DIGIT_W){1'b0}}, w_digit};

    always_comb begin
        logic [1:0] ph;
        ph    = r_phase;
        n_neg = r_neg;
        n_acc = r_acc;
        if (ph == PH_BLANK && !w_blank)
            ph = PH_SIGN;
        if (ph == PH_SIGN) begin
            if (r_char == CH_MINUS)
                n_neg = !r_neg;
            else if (r_char != CH_PLUS)
                ph = PH_DIGIT;
        end
        if (ph == PH_DIGIT) begin
            if (w_hit)
                n_acc = w_mac;
            else
                ph = PH_DONE;
        end
        n_phase = ph;
    end

    assign n_value = !w_base.base_ok ? '0 : (n_neg ? (ACC_W'(0) - n_acc) : n_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BLANK;
            r_acc   <= '0;
            r_neg   <= 1'b0;
        end else if (w_adv) begin
            if (r_last) begin
                r_phase <= PH_BLANK;
                r_acc   <= '0;
                r_neg   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_last) begin
            r_out_value <= n_value;
            r_out_ok    <= w_base.base_ok;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.value   = r_out_value;
    assign o_res.base_ok = r_out_ok;

    `STOI_ASSERT(a_bad_base_zero, (r_out_valid && !r_out_ok) |-> (r_out_value == '0), "invalid base must give zero")
    `STOI_ASSERT(a_last_gives_result, (w_adv && r_last) |=> r_out_valid, "last character produced no result")
    `STOI_ASSERT(a_last_clears, (w_adv && r_last) |=> (r_phase == PH_BLANK && r_acc == '0 && !r_neg), "parse state not cleared after last character")
    `STOI_ASSERT(a_done_sticks, (r_phase == PH_DONE && w_adv && !r_last) |=> (r_phase == PH_DONE), "parsing restarted before end of string")
    `STOI_ASSERT_ALWAYS(a_empty_ready, !r_in_valid |-> i_in.ready, "empty input stage refused a request")

endmodule
